// ===== rtl/bblur_pkg.sv =====
`timescale 1ns / 1ps
package bblur_pkg;

  localparam int unsigned DEF_MAX_WIDTH    = 2048;
  localparam int unsigned DEF_MAX_HEIGHT   = 2048;
  localparam int unsigned DEF_MAX_CHANNELS = 3;

  localparam int unsigned SAMPLE_W      = 8;
  localparam int unsigned SAMPLE_FIELDS = 3;
  localparam int unsigned DATA_W        = SAMPLE_W * SAMPLE_FIELDS;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;

  // one column of three samples, then nine samples
  localparam int unsigned COL_SUM_W = 10;
  localparam int unsigned SUM_W     = 12;

  // reciprocals scaled by 2^16, exact floor for sums below 4096
  localparam int unsigned RECIP_W     = 14;
  localparam int unsigned RECIP_SHIFT = 16;
  localparam logic [RECIP_W-1:0] RECIP_6 = 14'd10923;
  localparam logic [RECIP_W-1:0] RECIP_9 = 14'd7282;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_CHANNEL_COUNT = 3'd2,
    REG_REGION_LEFT   = 3'd3,
    REG_REGION_RIGHT  = 3'd4,
    REG_REGION_TOP    = 3'd5,
    REG_REGION_BOTTOM = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [11:0] image_width;
    logic [11:0] image_height;
    logic [1:0]  channel_count;
    logic [10:0] region_left;
    logic [11:0] region_right;
    logic [10:0] region_top;
    logic [11:0] region_bottom;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    image_width:   12'd2048,
    image_height:  12'd2048,
    channel_count: 2'd3,
    region_left:   11'd0,
    region_right:  12'd2048,
    region_top:    11'd0,
    region_bottom: 12'd2048
  };

  // neighbourhood shape and tags of one centre pixel
  typedef struct packed {
    logic use_l;
    logic use_r;
    logic use_t;
    logic use_b;
    logic in_rect;
    logic last;
  } tap_flags_t;

  typedef enum logic [1:0] {
    DIV_BY_4 = 2'd0,
    DIV_BY_6 = 2'd1,
    DIV_BY_9 = 2'd2
  } div_sel_t;

  function automatic logic [1:0] eff_channels(input logic [1:0] raw, input logic [1:0] lanes);
    logic [1:0] n;
    n = raw;
    if (n == 2'd0) n = 2'd1;
    if (n > lanes) n = lanes;
    return n;
  endfunction

endpackage

// ===== rtl/bblur_ram.sv =====
`timescale 1ns / 1ps
module bblur_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 2048,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first on a same-address collision
  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
    if (we) mem[waddr] <= wdata;
  end

endmodule

// ===== rtl/bblur_scan.sv =====
`timescale 1ns / 1ps
module bblur_scan #(
  parameter int unsigned MAX_WIDTH    = bblur_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT   = bblur_pkg::DEF_MAX_HEIGHT,
  parameter int unsigned MAX_CHANNELS = bblur_pkg::DEF_MAX_CHANNELS,
  localparam int unsigned NCH   = (MAX_CHANNELS < 3) ? MAX_CHANNELS : 3,
  localparam int unsigned PIX_W = bblur_pkg::SAMPLE_W * NCH,
  localparam int unsigned CW    = $clog2(MAX_WIDTH),
  localparam int unsigned XW    = CW + 1,
  localparam int unsigned YW    = $clog2(MAX_HEIGHT + 3)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          accept,
  input  logic                          action,
  input  logic [bblur_pkg::DATA_W-1:0]  samples,
  input  logic [XW-1:0]                 eff_w,
  input  logic [YW-1:0]                 eff_h,
  input  logic [1:0]                    chan_n,
  output logic [CW-1:0]                 rd_addr,
  output logic                          s1_valid,
  output logic [YW-1:0]                 s1_row,
  output logic [CW-1:0]                 s1_col,
  output logic [PIX_W-1:0]              s1_pix
);
  import bblur_pkg::*;

  logic [CW-1:0]    column_pos;
  logic [YW-1:0]    row_pos;
  logic [YW-1:0]    h_plus1;
  logic [CW-1:0]    cur_col;
  logic [YW-1:0]    cur_row;
  logic [XW-1:0]    step_col;
  logic [CW-1:0]    col_next;
  logic [YW-1:0]    row_next;
  logic [PIX_W-1:0] pix;

  always_comb begin
    h_plus1 = eff_h + YW'(1);

    // slot this item lands in
    cur_col = column_pos;
    cur_row = row_pos;
    if ({1'b0, column_pos} >= eff_w) begin
      cur_col = '0;
      cur_row = row_pos + YW'(1);
    end
    if (cur_row > h_plus1 || (cur_row == h_plus1 && cur_col != '0)) begin
      cur_row = '0;
      cur_col = '0;
    end

    // slot of the following item
    step_col = {1'b0, cur_col} + XW'(1);
    col_next = step_col[CW-1:0];
    row_next = cur_row;
    if (step_col >= eff_w) begin
      col_next = '0;
      row_next = cur_row + YW'(1);
    end
    if (row_next > h_plus1 || (row_next == h_plus1 && col_next != '0)) begin
      row_next = '0;
      col_next = '0;
    end
  end

  // action and drain slots, unused channels are 0
  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      if (!action && cur_row < eff_h && ch < int'(chan_n)) begin
        pix[ch*SAMPLE_W +: SAMPLE_W] = samples[ch*SAMPLE_W +: SAMPLE_W];
      end else begin
        pix[ch*SAMPLE_W +: SAMPLE_W] = '0;
      end
    end
  end

  assign rd_addr = cur_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_pos <= '0;
      row_pos    <= '0;
      s1_valid   <= 1'b0;
    end else begin
      if (accept) begin
        column_pos <= col_next;
        row_pos    <= row_next;
      end
      if (adv) s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_row <= cur_row;
      s1_col <= cur_col;
      s1_pix <= pix;
    end
  end

endmodule

// ===== rtl/bblur_window.sv =====
`timescale 1ns / 1ps
module bblur_window #(
  parameter int unsigned MAX_WIDTH    = bblur_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT   = bblur_pkg::DEF_MAX_HEIGHT,
  parameter int unsigned MAX_CHANNELS = bblur_pkg::DEF_MAX_CHANNELS,
  localparam int unsigned NCH   = (MAX_CHANNELS < 3) ? MAX_CHANNELS : 3,
  localparam int unsigned PIX_W = bblur_pkg::SAMPLE_W * NCH,
  localparam int unsigned CSW   = bblur_pkg::COL_SUM_W * NCH,
  localparam int unsigned CW    = $clog2(MAX_WIDTH),
  localparam int unsigned XW    = CW + 1,
  localparam int unsigned YW    = $clog2(MAX_HEIGHT + 3)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    adv,
  input  logic                    rd_en,
  input  logic [CW-1:0]           rd_addr,
  input  logic                    s1_valid,
  input  logic [YW-1:0]           s1_row,
  input  logic [CW-1:0]           s1_col,
  input  logic [PIX_W-1:0]        s1_pix,
  input  logic [XW-1:0]           eff_w,
  input  logic [YW-1:0]           eff_h,
  input  bblur_pkg::cfg_t         cfg,
  input  logic [PIX_W-1:0]        upper_q,
  input  logic [PIX_W-1:0]        middle_q,
  output logic                    wr_en,
  output logic [CW-1:0]           wr_addr,
  output logic [PIX_W-1:0]        upper_d,
  output logic [PIX_W-1:0]        middle_d,
  output logic                    s2_valid,
  output bblur_pkg::tap_flags_t   s2_flags,
  output logic [CSW-1:0]          s2_sum_l,
  output logic [CSW-1:0]          s2_sum_m,
  output logic [CSW-1:0]          s2_sum_r,
  output logic [PIX_W-1:0]        s2_center
);
  import bblur_pkg::*;

  function automatic logic [COL_SUM_W-1:0] col_sum(
    input logic [SAMPLE_W-1:0] t, input logic [SAMPLE_W-1:0] m, input logic [SAMPLE_W-1:0] b,
    input logic use_t, input logic use_b);
    logic [COL_SUM_W-1:0] s;
    s = COL_SUM_W'(m);
    if (use_t) s = s + COL_SUM_W'(t);
    if (use_b) s = s + COL_SUM_W'(b);
    return s;
  endfunction

  logic             fwd_hit;
  logic [PIX_W-1:0] fwd_upper;
  logic [PIX_W-1:0] fwd_middle;
  logic [PIX_W-1:0] col_top;
  logic [PIX_W-1:0] col_mid;
  logic [PIX_W-1:0] win [6];

  logic             col_zero;
  logic [1:0]       row_off;
  logic [CW-1:0]    cc;
  logic [YW-1:0]    cr;
  logic             produce;
  tap_flags_t       flags;
  logic [CSW-1:0]   sum_l;
  logic [CSW-1:0]   sum_m;
  logic [CSW-1:0]   sum_r;

  // the line entry may have been written back while it was being read
  assign col_top = fwd_hit ? fwd_upper  : upper_q;
  assign col_mid = fwd_hit ? fwd_middle : middle_q;

  assign wr_en    = adv && s1_valid;
  assign wr_addr  = s1_col;
  assign upper_d  = col_mid;
  assign middle_d = s1_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (rd_en) begin
      fwd_hit <= wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_upper  <= col_mid;
      fwd_middle <= s1_pix;
    end
  end

  // centre is one row and one column behind the slot, with column wrap
  always_comb begin
    col_zero      = (s1_col == '0);
    row_off       = col_zero ? 2'd2 : 2'd1;
    cc            = col_zero ? CW'(eff_w - XW'(1)) : s1_col - CW'(1);
    cr            = s1_row - YW'(row_off);
    produce       = (s1_row >= YW'(row_off)) && (cr < eff_h);
    flags.use_l   = (cc != '0);
    flags.use_r   = ({1'b0, cc} != eff_w - XW'(1));
    flags.use_t   = (cr != '0);
    flags.use_b   = (cr != eff_h - YW'(1));
    flags.in_rect = (cc >= cfg.region_left) && (cc < cfg.region_right) &&
                    (cr >= cfg.region_top) && (cr < cfg.region_bottom);
    flags.last    = (cr == eff_h - YW'(1)) && ({1'b0, cc} == eff_w - XW'(1));
  end

  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      sum_l[ch*COL_SUM_W +: COL_SUM_W] = col_sum(
        win[0][ch*SAMPLE_W +: SAMPLE_W], win[1][ch*SAMPLE_W +: SAMPLE_W],
        win[2][ch*SAMPLE_W +: SAMPLE_W], flags.use_t, flags.use_b);
      sum_m[ch*COL_SUM_W +: COL_SUM_W] = col_sum(
        win[3][ch*SAMPLE_W +: SAMPLE_W], win[4][ch*SAMPLE_W +: SAMPLE_W],
        win[5][ch*SAMPLE_W +: SAMPLE_W], flags.use_t, flags.use_b);
      sum_r[ch*COL_SUM_W +: COL_SUM_W] = col_sum(
        col_top[ch*SAMPLE_W +: SAMPLE_W], col_mid[ch*SAMPLE_W +: SAMPLE_W],
        s1_pix[ch*SAMPLE_W +: SAMPLE_W], flags.use_t, flags.use_b);
    end
  end

  // two columns of three rows
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 6; k++) win[k] <= '0;
    end else if (wr_en) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= col_top;
      win[4] <= col_mid;
      win[5] <= s1_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid && produce;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_flags  <= flags;
      s2_sum_l  <= sum_l;
      s2_sum_m  <= sum_m;
      s2_sum_r  <= sum_r;
      s2_center <= win[4];
    end
  end

endmodule

// ===== rtl/bblur_mean.sv =====
`timescale 1ns / 1ps
module bblur_mean #(
  parameter int unsigned MAX_CHANNELS = bblur_pkg::DEF_MAX_CHANNELS,
  localparam int unsigned NCH   = (MAX_CHANNELS < 3) ? MAX_CHANNELS : 3,
  localparam int unsigned PIX_W = bblur_pkg::SAMPLE_W * NCH,
  localparam int unsigned CSW   = bblur_pkg::COL_SUM_W * NCH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic [1:0]                    chan_n,
  input  logic                          s2_valid,
  input  bblur_pkg::tap_flags_t         s2_flags,
  input  logic [CSW-1:0]                s2_sum_l,
  input  logic [CSW-1:0]                s2_sum_m,
  input  logic [CSW-1:0]                s2_sum_r,
  input  logic [PIX_W-1:0]              s2_center,
  output logic                          res_valid,
  output logic [bblur_pkg::DATA_W-1:0]  res_data,
  output logic                          res_inside,
  output logic                          res_last
);
  import bblur_pkg::*;

  logic [SUM_W-1:0] total [NCH];
  div_sel_t         sel;
  logic             rows3;
  logic             cols3;

  logic             s3_valid;
  logic [SUM_W-1:0] s3_total [NCH];
  div_sel_t         s3_sel;
  logic [PIX_W-1:0] s3_center;
  logic             s3_inside;
  logic             s3_last;

  logic [SUM_W+RECIP_W-1:0] prod [NCH];
  logic [SAMPLE_W-1:0]      quot [NCH];

  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      total[ch] = SUM_W'(s2_sum_m[ch*COL_SUM_W +: COL_SUM_W]);
      if (s2_flags.use_l) total[ch] = total[ch] + SUM_W'(s2_sum_l[ch*COL_SUM_W +: COL_SUM_W]);
      if (s2_flags.use_r) total[ch] = total[ch] + SUM_W'(s2_sum_r[ch*COL_SUM_W +: COL_SUM_W]);
    end
    rows3 = s2_flags.use_t && s2_flags.use_b;
    cols3 = s2_flags.use_l && s2_flags.use_r;
    if (rows3 && cols3)      sel = DIV_BY_9;
    else if (rows3 || cols3) sel = DIV_BY_6;
    else                     sel = DIV_BY_4;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int ch = 0; ch < NCH; ch++) s3_total[ch] <= total[ch];
      s3_sel    <= sel;
      s3_center <= s2_center;
      s3_inside <= s2_flags.in_rect;
      s3_last   <= s2_flags.last;
    end
  end

  // divide by reciprocal multiply, corners by shift
  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      unique case (s3_sel)
        DIV_BY_9: begin
          prod[ch] = (SUM_W+RECIP_W)'(s3_total[ch]) * (SUM_W+RECIP_W)'(RECIP_9);
          quot[ch] = prod[ch][RECIP_SHIFT +: SAMPLE_W];
        end
        DIV_BY_6: begin
          prod[ch] = (SUM_W+RECIP_W)'(s3_total[ch]) * (SUM_W+RECIP_W)'(RECIP_6);
          quot[ch] = prod[ch][RECIP_SHIFT +: SAMPLE_W];
        end
        DIV_BY_4: begin
          prod[ch] = '0;
          quot[ch] = s3_total[ch][2 +: SAMPLE_W];
        end
        default: begin
          prod[ch] = '0;
          quot[ch] = '0;
        end
      endcase
    end
  end

  always_comb begin
    res_data = '0;
    for (int ch = 0; ch < NCH; ch++) begin
      if (ch < int'(chan_n)) begin
        res_data[ch*SAMPLE_W +: SAMPLE_W] =
          s3_inside ? quot[ch] : s3_center[ch*SAMPLE_W +: SAMPLE_W];
      end
    end
  end

  assign res_valid  = s3_valid;
  assign res_inside = s3_inside;
  assign res_last   = s3_last;

endmodule

// ===== rtl/box_blur_3x3_edge_aware.sv =====
`timescale 1ns / 1ps
// channel   dir  handshake                   payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: sample_a, sample_b, sample_c; tuser: action
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: blurred_a/b/c; tuser: in_region; tlast
// cfg       in   cfg_valid/cfg_ready          cfg_index: register, cfg_data: value
//
// one item per clock while s_axis_tready is high; a result reaches the output register after
// the registered line store read and stage 1, then the sum and divide stages
// each item does one read and one write-back of its column in both line stores
// reset (synchronous) clears position, window, pipeline and output valids; line stores
// are not cleared and hold nothing valid until written
// m_axis_tready low parks one result in a skid register; s_axis_tready then drops
module box_blur_3x3_edge_aware #(
  parameter int unsigned MAX_WIDTH    = bblur_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT   = bblur_pkg::DEF_MAX_HEIGHT,
  parameter int unsigned MAX_CHANNELS = bblur_pkg::DEF_MAX_CHANNELS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [bblur_pkg::DATA_W-1:0]       s_axis_tdata,   // sample_a, sample_b, sample_c
  input  logic [0:0]                         s_axis_tuser,   // action
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [bblur_pkg::DATA_W-1:0]       m_axis_tdata,   // blurred_a, blurred_b, blurred_c
  output logic [0:0]                         m_axis_tuser,   // in_region
  output logic                               m_axis_tlast,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bblur_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bblur_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import bblur_pkg::*;

  localparam int unsigned NCH   = (MAX_CHANNELS < 3) ? MAX_CHANNELS : 3;
  localparam int unsigned PIX_W = SAMPLE_W * NCH;
  localparam int unsigned CSW   = COL_SUM_W * NCH;
  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned XW    = CW + 1;
  localparam int unsigned YW    = $clog2(MAX_HEIGHT + 3);

  // configuration registers
  cfg_t          cfg;
  logic [XW-1:0] eff_w;
  logic [YW-1:0] eff_h;
  logic [1:0]    chan_n;

  // pipeline control
  logic adv;
  logic accept;

  // stage 1 and line stores
  logic [CW-1:0]    rd_addr;
  logic             s1_valid;
  logic [YW-1:0]    s1_row;
  logic [CW-1:0]    s1_col;
  logic [PIX_W-1:0] s1_pix;
  logic [PIX_W-1:0] upper_q;
  logic [PIX_W-1:0] middle_q;
  logic             wr_en;
  logic [CW-1:0]    wr_addr;
  logic [PIX_W-1:0] upper_d;
  logic [PIX_W-1:0] middle_d;

  // stage 2
  logic             s2_valid;
  tap_flags_t       s2_flags;
  logic [CSW-1:0]   s2_sum_l;
  logic [CSW-1:0]   s2_sum_m;
  logic [CSW-1:0]   s2_sum_r;
  logic [PIX_W-1:0] s2_center;

  // result and output buffer
  logic              res_valid;
  logic [DATA_W-1:0] res_data;
  logic              res_inside;
  logic              res_last;
  logic              push;
  logic              skid_valid;
  logic [DATA_W-1:0] skid_data;
  logic              skid_inside;
  logic              skid_last;

  // config writes must arrive only while the pipeline is empty; the block does not enforce it
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:   cfg.image_width   <= cfg_data;
        REG_IMAGE_HEIGHT:  cfg.image_height  <= cfg_data;
        REG_CHANNEL_COUNT: cfg.channel_count <= cfg_data[1:0];
        REG_REGION_LEFT:   cfg.region_left   <= cfg_data[10:0];
        REG_REGION_RIGHT:  cfg.region_right  <= cfg_data;
        REG_REGION_TOP:    cfg.region_top    <= cfg_data[10:0];
        REG_REGION_BOTTOM: cfg.region_bottom <= cfg_data;
        default: ;
      endcase
    end
  end

  // frame size saturated into the supported range
  always_comb begin
    if (cfg.image_width > MAX_WIDTH)  eff_w = XW'(MAX_WIDTH);
    else if (cfg.image_width < 2)     eff_w = XW'(2);
    else                              eff_w = XW'(cfg.image_width);
    if (cfg.image_height > MAX_HEIGHT) eff_h = YW'(MAX_HEIGHT);
    else if (cfg.image_height < 2)     eff_h = YW'(2);
    else                               eff_h = YW'(cfg.image_height);
  end

  assign chan_n = eff_channels(cfg.channel_count, 2'(NCH));

  // the whole pipeline moves unless the skid register holds a result
  assign adv           = !skid_valid;
  assign s_axis_tready = adv;
  assign accept        = s_axis_tvalid && adv;

  bblur_scan #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .accept   (accept),
    .action   (s_axis_tuser[0]),
    .samples  (s_axis_tdata),
    .eff_w    (eff_w),
    .eff_h    (eff_h),
    .chan_n   (chan_n),
    .rd_addr  (rd_addr),
    .s1_valid (s1_valid),
    .s1_row   (s1_row),
    .s1_col   (s1_col),
    .s1_pix   (s1_pix)
  );

  // line two rows up
  bblur_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_upper_line (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (upper_d),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (upper_q)
  );

  // line one row up
  bblur_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_middle_line (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (middle_d),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (middle_q)
  );

  bblur_window #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .rd_en     (accept),
    .rd_addr   (rd_addr),
    .s1_valid  (s1_valid),
    .s1_row    (s1_row),
    .s1_col    (s1_col),
    .s1_pix    (s1_pix),
    .eff_w     (eff_w),
    .eff_h     (eff_h),
    .cfg       (cfg),
    .upper_q   (upper_q),
    .middle_q  (middle_q),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .upper_d   (upper_d),
    .middle_d  (middle_d),
    .s2_valid  (s2_valid),
    .s2_flags  (s2_flags),
    .s2_sum_l  (s2_sum_l),
    .s2_sum_m  (s2_sum_m),
    .s2_sum_r  (s2_sum_r),
    .s2_center (s2_center)
  );

  bblur_mean #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_mean (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .chan_n     (chan_n),
    .s2_valid   (s2_valid),
    .s2_flags   (s2_flags),
    .s2_sum_l   (s2_sum_l),
    .s2_sum_m   (s2_sum_m),
    .s2_sum_r   (s2_sum_r),
    .s2_center  (s2_center),
    .res_valid  (res_valid),
    .res_data   (res_data),
    .res_inside (res_inside),
    .res_last   (res_last)
  );

  // output register with one skid entry behind it
  assign push = res_valid && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_valid    <= 1'b0;
    end else if (!m_axis_tvalid || m_axis_tready) begin
      if (skid_valid) begin
        m_axis_tvalid <= 1'b1;
        skid_valid    <= 1'b0;
      end else begin
        m_axis_tvalid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_axis_tvalid || m_axis_tready) begin
      if (skid_valid) begin
        m_axis_tdata    <= skid_data;
        m_axis_tuser[0] <= skid_inside;
        m_axis_tlast    <= skid_last;
      end else if (push) begin
        m_axis_tdata    <= res_data;
        m_axis_tuser[0] <= res_inside;
        m_axis_tlast    <= res_last;
      end
    end else if (push) begin
      skid_data   <= res_data;
      skid_inside <= res_inside;
      skid_last   <= res_last;
    end
  end

`ifndef SYNTHESIS
  // a parked result always has a presented result ahead of it
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_axis_tvalid)
    else $error("skid entry held without an output entry");

  // skid fills only when the output entry was stalled
  a_skid_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(m_axis_tvalid && !m_axis_tready))
    else $error("skid filled while output was free");

  // every input transfer enters the line store stage on the next edge
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> s1_valid)
    else $error("accepted item lost before line store stage");
`endif

endmodule
